/* hw/rtl/aabb_pkg.sv */
// aabb_pkg: shared types, command and status codes for the box overlap finder
// no dependencies
`timescale 1ns / 1ps
package aabb_pkg;

    localparam int unsigned DefMaxEntities = 8;
    localparam int unsigned CmdQueueDepth = 2;

    typedef enum logic [2:0] {
        KIND_ADD    = 3'd0,
        KIND_REMOVE = 3'd1,
        KIND_CLEAR  = 3'd2,
        KIND_ENUM   = 3'd3,
        KIND_QUERY  = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_SCAN  = 2'd1,
        BK_SHIFT = 2'd2,
        BK_DONE  = 2'd3
    } t_back_state;

    typedef struct packed {
        logic [2:0]         kind;
        logic [15:0]        entity_id;
        logic signed [31:0] min_x;
        logic signed [31:0] min_y;
        logic signed [31:0] min_z;
        logic signed [31:0] max_x;
        logic signed [31:0] max_y;
        logic signed [31:0] max_z;
    } t_in_item;

    typedef struct packed {
        logic [15:0] first_id;
        logic [15:0] second_id;
        logic        pair_valid;
        logic [1:0]  status;
        logic        last;
    } t_out_item;

    // closed interval overlap on all three axes
    function automatic logic boxes_overlap(
        input logic signed [31:0] a_lx, input logic signed [31:0] a_ly,
        input logic signed [31:0] a_lz, input logic signed [31:0] a_hx,
        input logic signed [31:0] a_hy, input logic signed [31:0] a_hz,
        input logic signed [31:0] b_lx, input logic signed [31:0] b_ly,
        input logic signed [31:0] b_lz, input logic signed [31:0] b_hx,
        input logic signed [31:0] b_hy, input logic signed [31:0] b_hz);
        return (a_lx <= b_hx) && (b_lx <= a_hx) &&
               (a_ly <= b_hy) && (b_ly <= a_hy) &&
               (a_lz <= b_hz) && (b_lz <= a_hz);
    endfunction

endpackage

/* hw/rtl/aabb_cmd_queue.sv */
// aabb_cmd_queue: front part, takes command beats into a short fifo
// depends on aabb_pkg
`timescale 1ns / 1ps
module aabb_cmd_queue
    import aabb_pkg::*;
#(
    parameter int unsigned DEPTH = CmdQueueDepth
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_item,
    output logic     o_full,
    output logic     o_empty,
    input  logic     i_pop,
    output t_in_item o_item
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_in_item       r_mem [DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [AW:0]    r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end
endmodule

/* hw/rtl/aabb_exec.sv */
// aabb_exec: back part, entry table and the per-command sequencer
// depends on aabb_pkg
`timescale 1ns / 1ps
module aabb_exec
    import aabb_pkg::*;
#(
    parameter int unsigned MAX_ENTITIES = DefMaxEntities
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_empty,
    input  t_in_item  i_cmd,
    output logic      o_pop,
    output logic      o_strobe,
    output t_out_item o_result
);
    localparam int unsigned IW = $clog2(MAX_ENTITIES);
    localparam int unsigned CW = $clog2(MAX_ENTITIES + 1);

    logic [15:0]        r_id  [MAX_ENTITIES];
    logic signed [31:0] r_lx [MAX_ENTITIES], r_ly [MAX_ENTITIES], r_lz [MAX_ENTITIES];
    logic signed [31:0] r_hx [MAX_ENTITIES], r_hy [MAX_ENTITIES], r_hz [MAX_ENTITIES];

    t_back_state r_state, n_state;
    t_in_item    r_cmd;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_i, r_j;
    logic          r_any;
    logic          r_found;
    t_out_item     r_pend;
    logic [CW-1:0] n_i, n_j;

    logic [IW-1:0] ai, aj;
    logic          hit_pair, hit_query, id_match, hit_id, scan_end;
    logic          hit;
    logic          emit;
    t_out_item     res;
    t_out_item     hit_beat;

    assign ai = r_i[IW-1:0];
    assign aj = r_j[IW-1:0];

    // one box test per cycle
    assign hit_pair = boxes_overlap(r_lx[ai], r_ly[ai], r_lz[ai], r_hx[ai], r_hy[ai],
                                    r_hz[ai], r_lx[aj], r_ly[aj], r_lz[aj], r_hx[aj],
                                    r_hy[aj], r_hz[aj]);
    assign hit_query = boxes_overlap(r_lx[ai], r_ly[ai], r_lz[ai], r_hx[ai], r_hy[ai],
                                     r_hz[ai], r_cmd.min_x, r_cmd.min_y, r_cmd.min_z,
                                     r_cmd.max_x, r_cmd.max_y, r_cmd.max_z);
    assign id_match = (r_id[ai] == r_cmd.entity_id);
    assign hit_id = id_match && (r_count != '0);

    // a reported pair is held back one hit so the final one can carry last
    assign hit = (r_cmd.kind == KIND_ENUM && r_count >= CW'(2) && hit_pair) ||
                 (r_cmd.kind == KIND_QUERY && r_count != '0 && hit_query);
    assign hit_beat = '{first_id: r_id[ai],
                        second_id: (r_cmd.kind == KIND_ENUM) ? r_id[aj] : r_cmd.entity_id,
                        pair_valid: 1'b1, status: ST_OK, last: 1'b0};

    // scan index step and end detection
    always_comb begin
        n_i = r_i;
        n_j = r_j;
        scan_end = 1'b0;
        case (r_cmd.kind)
            KIND_ENUM: begin
                if (r_j + 1'b1 < r_count) begin
                    n_j = r_j + 1'b1;
                end else begin
                    n_i = r_i + 1'b1;
                    n_j = r_i + 2'd2;
                    scan_end = (r_i + 2'd2 >= r_count);
                end
            end
            default: begin
                n_i = r_i + 1'b1;
                scan_end = (r_i + 1'b1 >= r_count);
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: if (!i_q_empty) n_state = BK_SCAN;
            BK_SCAN: begin
                if (r_cmd.kind == KIND_ENUM || r_cmd.kind == KIND_QUERY) begin
                    if (r_count == '0 || scan_end ||
                        (r_cmd.kind == KIND_ENUM && r_count < CW'(2))) begin
                        n_state = BK_DONE;
                    end
                end else if (r_cmd.kind == KIND_ADD || r_cmd.kind == KIND_REMOVE) begin
                    if (r_count == '0 || scan_end || hit_id) begin
                        n_state = (r_cmd.kind == KIND_REMOVE && hit_id) ? BK_SHIFT
                                                                        : BK_DONE;
                    end
                end else begin
                    n_state = BK_DONE;
                end
            end
            BK_SHIFT: if (r_i + 1'b1 >= r_count) n_state = BK_DONE;
            BK_DONE:  n_state = BK_IDLE;
            default:  n_state = BK_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        res = '0;
        emit = 1'b0;
        o_pop = (r_state == BK_IDLE) && !i_q_empty;
        case (r_state)
            BK_SCAN: begin
                if (hit && r_any) begin
                    emit = 1'b1;
                    res = r_pend;
                end
            end
            BK_DONE: begin
                case (r_cmd.kind)
                    KIND_ADD: begin
                        emit = 1'b1;
                        if (r_found) res.status = ST_DUPLICATE;
                        else if (r_count == CW'(MAX_ENTITIES)) res.status = ST_FULL;
                    end
                    KIND_REMOVE: begin
                        emit = 1'b1;
                        if (!r_found) res.status = ST_NOT_FOUND;
                    end
                    KIND_ENUM, KIND_QUERY: begin
                        emit = 1'b1;
                        if (r_any) res = r_pend;
                    end
                    default: emit = 1'b1;
                endcase
                res.last = 1'b1;
            end
            default: ;
        endcase
        o_strobe = emit;
        o_result = res;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_count <= '0;
            r_any <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                BK_IDLE: begin
                    r_any <= 1'b0;
                    r_found <= 1'b0;
                end
                BK_SCAN: begin
                    if (hit) r_any <= 1'b1;
                    if ((r_cmd.kind == KIND_ADD || r_cmd.kind == KIND_REMOVE) && hit_id) begin
                        r_found <= 1'b1;
                    end
                    if (r_cmd.kind == KIND_CLEAR) r_count <= '0;
                end
                BK_DONE: begin
                    if (r_cmd.kind == KIND_ADD && !r_found &&
                        r_count != CW'(MAX_ENTITIES)) begin
                        r_count <= r_count + 1'b1;
                    end
                    if (r_cmd.kind == KIND_REMOVE && r_found) r_count <= r_count - 1'b1;
                end
                default: ;
            endcase
        end
    end

    // command, held pair beat and scan indexes
    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                r_cmd <= i_cmd;
                r_i <= '0;
                r_j <= CW'(1);
            end
            BK_SCAN: begin
                if (hit) r_pend <= hit_beat;
                // a remove match keeps the index where the move-down starts
                if (!(r_cmd.kind == KIND_REMOVE && hit_id)) begin
                    r_i <= n_i;
                end
                r_j <= n_j;
            end
            BK_SHIFT: r_i <= r_i + 1'b1;
            default: ;
        endcase
    end

    // entry table: append on add, move down one on remove
    always_ff @(posedge i_clk) begin
        if (r_state == BK_DONE && r_cmd.kind == KIND_ADD && !r_found &&
            r_count != CW'(MAX_ENTITIES)) begin
            r_id[r_count[IW-1:0]] <= r_cmd.entity_id;
            r_lx[r_count[IW-1:0]] <= r_cmd.min_x;
            r_ly[r_count[IW-1:0]] <= r_cmd.min_y;
            r_lz[r_count[IW-1:0]] <= r_cmd.min_z;
            r_hx[r_count[IW-1:0]] <= r_cmd.max_x;
            r_hy[r_count[IW-1:0]] <= r_cmd.max_y;
            r_hz[r_count[IW-1:0]] <= r_cmd.max_z;
        end else if (r_state == BK_SHIFT && r_i + 1'b1 < r_count) begin
            r_id[ai] <= r_id[IW'(r_i + 1'b1)];
            r_lx[ai] <= r_lx[IW'(r_i + 1'b1)];
            r_ly[ai] <= r_ly[IW'(r_i + 1'b1)];
            r_lz[ai] <= r_lz[IW'(r_i + 1'b1)];
            r_hx[ai] <= r_hx[IW'(r_i + 1'b1)];
            r_hy[ai] <= r_hy[IW'(r_i + 1'b1)];
            r_hz[ai] <= r_hz[IW'(r_i + 1'b1)];
        end
    end
endmodule

/* hw/rtl/aabb_pair_overlap_finder.sv */
// the back part takes one command at a time and ends each with a beat marked last
// it scans the table: add and remove stop at a matching id, remove then moves entries down,
// enumerate tests each pair of entries, query each entry against the box; clear empties it
// a two-beat command queue lets start be taken while the back part runs
// reset: synchronous active low, empties queue and table; results cannot be stalled
`timescale 1ns / 1ps
module aabb_pair_overlap_finder
    import aabb_pkg::*;
#(
    parameter int unsigned MAX_ENTITIES = DefMaxEntities
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_strobe,
    output t_out_item o_result
);
    logic     q_full, q_empty, q_pop;
    t_in_item q_item;

    assign busy = q_full;

    // front: command queue
    aabb_cmd_queue #(.DEPTH(CmdQueueDepth)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(start && !q_full), .i_item(i_item),
        .o_full(q_full), .o_empty(q_empty),
        .i_pop(q_pop), .o_item(q_item)
    );

    // back: table and sequencer
    aabb_exec #(.MAX_ENTITIES(MAX_ENTITIES)) u_exec (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_empty(q_empty), .i_cmd(q_item),
        .o_pop(q_pop),
        .o_strobe(o_strobe), .o_result(o_result)
    );
endmodule

/* hw/rtl/aabb_checker.sv */
// aabb_checker: port-level assertions on the overlap finder
// depends on aabb_pkg, binds to aabb_pair_overlap_finder
`timescale 1ns / 1ps
module aabb_checker
    import aabb_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      busy,
    input logic      o_strobe,
    input t_out_item o_result
);
    // pair beats always carry ok status
    a_pair_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.pair_valid |-> o_result.status == ST_OK)
        else $error("pair beat with bad status");

    // non-pair beats are final and carry zero ids
    a_cmd_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.pair_valid |-> o_result.last &&
            o_result.first_id == '0 && o_result.second_id == '0)
        else $error("non-pair beat malformed");

    // no strobe and no busy right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe && !busy)
        else $error("activity after reset");
endmodule

bind aabb_pair_overlap_finder aabb_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .busy(busy),
    .o_strobe(o_strobe), .o_result(o_result)
);
